// ----- rtl/mrad_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mrad_pkg: shared types and constants for the MMIO region decoder
// Operation and status codes, region entry layout and compare unit bundles.
// ----------------------------------------------------------------------------
package mrad_pkg;

	localparam int unsigned AddrWidth    = 64;
	localparam int unsigned GenWidth     = 32;
	localparam int unsigned IndexWidth   = 4;
	localparam int unsigned DefaultSlots = 16;

	typedef enum logic [1:0] {
		OP_REGISTER = 2'd0,
		OP_READ     = 2'd1,
		OP_WRITE    = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		STS_OK            = 3'd0,
		STS_BAD_EXTENT    = 3'd1,
		STS_TABLE_FULL    = 3'd2,
		STS_OVERLAP       = 3'd3,
		STS_NO_REGION     = 3'd4,
		STS_NOT_PERMITTED = 3'd5
	} status_t;

	localparam int unsigned PermReadBit  = 0;
	localparam int unsigned PermWriteBit = 1;

	typedef struct packed {
		logic [AddrWidth-1:0] start;
		logic [AddrWidth-1:0] limit;
		logic [1:0]           perm;
	} entry_t;

	typedef struct packed {
		logic [AddrWidth-1:0] key_lo;
		logic [AddrWidth-1:0] key_hi;
	} cmp_req_t;

	typedef struct packed {
		logic                 hit;
		logic [AddrWidth-1:0] offset;
	} cmp_rsp_t;

	function automatic int unsigned idx_width(input int unsigned n);
		int unsigned w;
		w = 1;
		while ((1 << w) < n) begin
			w = w + 1;
		end
		return w;
	endfunction

	function automatic int unsigned cnt_width(input int unsigned n);
		int unsigned w;
		w = 1;
		while ((1 << w) <= n) begin
			w = w + 1;
		end
		return w;
	endfunction

endpackage
`default_nettype wire

// ----- rtl/mrad_table.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mrad_table: region table storage
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module mrad_table import mrad_pkg::*; #(
	parameter int unsigned REGION_SLOTS = DefaultSlots,
	localparam int unsigned IdxW = idx_width(REGION_SLOTS)
) (
	input  wire logic            clk,
	input  wire logic            wr_en,
	input  wire logic [IdxW-1:0] wr_addr,
	input  wire entry_t          wr_data,
	input  wire logic [IdxW-1:0] rd_addr,
	output entry_t               rd_data
);

	entry_t mem [REGION_SLOTS];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule
`default_nettype wire

// ----- rtl/mrad_cmp.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mrad_cmp: shared interval compare unit
// Tests a key interval against one stored region and forms the offset.
// ----------------------------------------------------------------------------
module mrad_cmp import mrad_pkg::*; (
	input  wire cmp_req_t req,
	input  wire entry_t   entry,
	output cmp_rsp_t      rsp
);

	// closed key interval [key_lo, key_hi] against half-open [start, limit)
	assign rsp.hit    = (entry.start <= req.key_hi) && (req.key_lo < entry.limit);
	assign rsp.offset = req.key_lo - entry.start;

endmodule
`default_nettype wire

// ----- rtl/mmio_region_address_decoder_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mmio_region_address_decoder_unit: MMIO region table and address decoder
// Registers address regions and decodes read and write accesses against them.
// ----------------------------------------------------------------------------
// After the input transfer, the item passes a check state, a scan of the N
// regions checked (at most the stored count, at least one when the table is
// not empty): one table read and one interval compare per stored region, in
// insertion order, and then a completion state.
// Items failing the extent, full or empty-table checks, and the unused op
// code, skip the scan. The input stalls from the transfer until the result
// moves to the output register, so a new item is not taken while the last
// one is still being checked, scanned or completed. A finished result sits
// in the output register so the next item can be taken while it waits; the
// next item then holds in completion until that register is free. The
// result carries the generation count as of that item.
module mmio_region_address_decoder_unit import mrad_pkg::*; #(
	parameter int unsigned REGION_SLOTS = DefaultSlots
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic [1:0]            op,
	input  wire logic [AddrWidth-1:0]  region_base,
	input  wire logic [AddrWidth-1:0]  region_size,
	input  wire logic                  allow_read,
	input  wire logic                  allow_write,
	input  wire logic [AddrWidth-1:0]  access_address,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic [2:0]                 status,
	output logic [IndexWidth-1:0]      region_index,
	output logic [AddrWidth-1:0]       offset,
	output logic [GenWidth-1:0]        generation
);

	localparam int unsigned IdxW = idx_width(REGION_SLOTS);
	localparam int unsigned CntW = cnt_width(REGION_SLOTS);

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_CHECK = 4'b0010,
		S_SCAN  = 4'b0100,
		S_DONE  = 4'b1000
	} state_t;

	state_t                 state_q;
	op_t                    op_q;
	logic [AddrWidth-1:0]   base_q;
	logic [AddrWidth-1:0]   addr_q;
	logic [AddrWidth:0]     sum_q;
	logic                   size_zero_q;
	logic [1:0]             perm_q;
	logic [AddrWidth-1:0]   key_lo_q;
	logic [AddrWidth-1:0]   key_hi_q;
	logic [IdxW-1:0]        idx_q;
	logic [CntW-1:0]        count_q;
	logic [GenWidth-1:0]    gen_q;

	status_t                res_status_q;
	logic [IndexWidth-1:0]  res_index_q;
	logic [AddrWidth-1:0]   res_offset_q;
	logic                   res_commit_q;

	logic                   out_valid_q;
	status_t                out_status_q;
	logic [IndexWidth-1:0]  out_index_q;
	logic [AddrWidth-1:0]   out_offset_q;
	logic [GenWidth-1:0]    out_gen_q;

	logic [IdxW-1:0]        rd_addr;
	entry_t                 rd_data;
	entry_t                 wr_data;
	logic                   wr_en;
	logic                   table_full;
	logic                   last_entry;
	logic                   out_free;
	logic                   need_ok;
	logic [IdxW+IndexWidth-1:0] idx_wide;
	logic [CntW+IndexWidth-1:0] cnt_wide;
	cmp_req_t               cmp_req;
	cmp_rsp_t               cmp_rsp;

	assign in_stall   = (state_q != S_IDLE);
	assign table_full = (count_q == CntW'(REGION_SLOTS));
	assign last_entry = ((CntW'(idx_q) + CntW'(1)) == count_q);
	assign out_free   = !out_valid_q || !out_stall;
	assign wr_en      = (state_q == S_DONE) && out_free && res_commit_q;
	assign idx_wide   = {{IndexWidth{1'b0}}, idx_q};
	assign cnt_wide   = {{IndexWidth{1'b0}}, count_q};
	assign need_ok    = (op_q == OP_READ) ? rd_data.perm[PermReadBit]
	                                      : rd_data.perm[PermWriteBit];

	always_comb begin
		rd_addr = '0;
		if (state_q == S_SCAN && idx_q != IdxW'(REGION_SLOTS - 1)) begin
			rd_addr = idx_q + IdxW'(1);
		end
	end

	assign wr_data.start = base_q;
	assign wr_data.limit = sum_q[AddrWidth-1:0];
	assign wr_data.perm  = perm_q;

	assign cmp_req.key_lo = key_lo_q;
	assign cmp_req.key_hi = key_hi_q;

	mrad_table #(
		.REGION_SLOTS(REGION_SLOTS)
	) u_table (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (count_q[IdxW-1:0]),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	mrad_cmp u_cmp (
		.req   (cmp_req),
		.entry (rd_data),
		.rsp   (cmp_rsp)
	);

	// item capture and scan registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					op_q        <= op_t'(op);
					base_q      <= region_base;
					addr_q      <= access_address;
					sum_q       <= {1'b0, region_base} + {1'b0, region_size};
					size_zero_q <= (region_size == '0);
					perm_q      <= {allow_write, allow_read};
					key_lo_q    <= (op_t'(op) == OP_REGISTER) ? region_base
					                                          : access_address;
				end
			end
			S_CHECK: begin
				key_hi_q <= (op_q == OP_REGISTER) ? (sum_q[AddrWidth-1:0] - AddrWidth'(1))
				                                  : addr_q;
			end
			default: begin
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			idx_q        <= '0;
			count_q      <= '0;
			gen_q        <= '0;
			res_status_q <= STS_OK;
			res_index_q  <= '0;
			res_offset_q <= '0;
			res_commit_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					idx_q        <= '0;
					res_index_q  <= '0;
					res_offset_q <= '0;
					res_commit_q <= 1'b0;
					state_q      <= S_DONE;
					case (op_q)
						OP_REGISTER: begin
							if (size_zero_q || sum_q[AddrWidth]) begin
								res_status_q <= STS_BAD_EXTENT;
							end else if (table_full) begin
								res_status_q <= STS_TABLE_FULL;
							end else if (count_q == '0) begin
								res_status_q <= STS_OK;
								res_index_q  <= cnt_wide[IndexWidth-1:0];
								res_commit_q <= 1'b1;
							end else begin
								state_q <= S_SCAN;
							end
						end
						OP_READ, OP_WRITE: begin
							if (count_q == '0) begin
								res_status_q <= STS_NO_REGION;
							end else begin
								state_q <= S_SCAN;
							end
						end
						default: begin
							res_status_q <= STS_NOT_PERMITTED;
						end
					endcase
				end
				S_SCAN: begin
					if (cmp_rsp.hit) begin
						state_q <= S_DONE;
						if (op_q == OP_REGISTER) begin
							res_status_q <= STS_OVERLAP;
						end else begin
							res_status_q <= need_ok ? STS_OK : STS_NOT_PERMITTED;
							res_index_q  <= idx_wide[IndexWidth-1:0];
							res_offset_q <= cmp_rsp.offset;
						end
					end else if (last_entry) begin
						state_q <= S_DONE;
						if (op_q == OP_REGISTER) begin
							res_status_q <= STS_OK;
							res_index_q  <= cnt_wide[IndexWidth-1:0];
							res_commit_q <= 1'b1;
						end else begin
							res_status_q <= STS_NO_REGION;
						end
					end else begin
						idx_q <= idx_q + IdxW'(1);
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
						if (res_commit_q) begin
							count_q <= count_q + CntW'(1);
							gen_q   <= gen_q + GenWidth'(1);
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			out_status_q <= res_status_q;
			out_index_q  <= res_index_q;
			out_offset_q <= res_offset_q;
			out_gen_q    <= res_commit_q ? (gen_q + GenWidth'(1)) : gen_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = out_status_q;
	assign region_index = out_index_q;
	assign offset       = out_offset_q;
	assign generation   = out_gen_q;

endmodule
`default_nettype wire
